// ===== hdl/aes_pkg.sv =====
// aes_pkg: shared types, s-box tables and round functions for the aes-256 block
// depends on nothing
`timescale 1ns / 1ps

package aes_pkg;

  localparam int ROUNDS    = 14;
  localparam int KEY_ROWS  = ROUNDS + 1;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 8'd7;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] POLY       = 8'h1b;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_DONE   = 4'b1000
  } ctrl_state_t;

  typedef struct packed {
    logic             load;      // input transaction, initial key add
    logic             step;      // one cipher round
    logic             finish;    // move result to output register
    logic             exp_step;  // one round key row
    logic [IDX_W-1:0] idx;       // round or key row number
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
  endfunction

  // multiply by a 4-bit constant coefficient
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] c);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    gmul = (c[0] ? a : 8'h00) ^ (c[1] ? x2 : 8'h00) ^ (c[2] ? x4 : 8'h00) ^
           (c[3] ? x8 : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(4*((c+r)%4)+r) -: 8] = s[127-8*(4*c+r) -: 8];
        end else begin
          t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
        end
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0]   m [4];
    logic [7:0]   acc;
    t = '0;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2; m[1] = 4'd3; m[2] = 4'd1; m[3] = 4'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) begin
          acc = acc ^ gmul(s[127-8*(4*c+j) -: 8], m[(j-r+4)%4]);
        end
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    mix_columns = t;
  endfunction

endpackage

// ===== hdl/aes_ctrl.sv =====
// aes_ctrl: sequencer for key expansion and the round loop
// depends on aes_pkg
`timescale 1ns / 1ps

module aes_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  aes_pkg::dp_status_t                status,
  output aes_pkg::dp_cmd_t                   cmd
);

  aes_pkg::ctrl_state_t            state, state_next;
  logic [aes_pkg::IDX_W-1:0]       idx, idx_next;
  logic                            key_write;
  logic                            in_fire;
  logic                            idx_last;

  assign cfg_ready = (state == aes_pkg::ST_IDLE);
  assign in_ready  = (state == aes_pkg::ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign idx_last  = (idx == aes_pkg::IDX_W'(aes_pkg::ROUNDS));
  assign key_write = cfg_valid && cfg_ready &&
                     (cfg_index == aes_pkg::REG_KEY_WORD_3 ||
                      cfg_index == aes_pkg::REG_KEY_WORD_2 ||
                      cfg_index == aes_pkg::REG_KEY_WORD_1 ||
                      cfg_index == aes_pkg::REG_KEY_WORD_0);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      aes_pkg::ST_IDLE: begin
        if (key_write) begin
          state_next = aes_pkg::ST_EXPAND;
          idx_next   = '0;
        end else if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = aes_pkg::ST_RUN;
          idx_next   = aes_pkg::IDX_W'(1);
        end
      end
      aes_pkg::ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        idx_next     = idx + 1'b1;
        if (idx_last) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      aes_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        idx_next = idx + 1'b1;
        if (idx_last) begin
          state_next = aes_pkg::ST_DONE;
        end
      end
      aes_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = aes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ===== hdl/aes_dp.sv =====
// aes_dp: round key store and expansion, round datapath, chaining value, output register
// depends on aes_pkg
`timescale 1ns / 1ps

module aes_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  aes_pkg::dp_cmd_t     cmd,
  output aes_pkg::dp_status_t  status,
  input  logic [255:0]         key,
  input  logic [127:0]         iv,
  input  logic                 cbc,
  input  logic                 decrypt,
  input  logic [127:0]         block_in,
  input  logic                 start_of_message,
  output logic [63:0]          result_high,
  output logic [63:0]          result_low,
  output logic                 out_valid,
  input  logic                 out_ready
);

  logic [127:0] round_key [aes_pkg::KEY_ROWS];
  logic [127:0] prev2, prev1;
  logic [7:0]   rcon;
  logic [127:0] exp_row;
  logic [31:0]  exp_t;
  logic [127:0] state;
  logic [127:0] saved_in;
  logic [127:0] chain;
  logic [127:0] chain_use;
  logic [127:0] round_out;
  logic [127:0] rk_sel;
  logic [aes_pkg::IDX_W-1:0] key_idx;
  logic         last;
  logic [127:0] enc_t, dec_t;

  // key schedule: one 128-bit row per cycle
  always_comb begin
    exp_t   = '0;
    exp_row = '0;
    if (cmd.idx == '0) begin
      exp_row = key[255:128];
    end else if (cmd.idx == aes_pkg::IDX_W'(1)) begin
      exp_row = key[127:0];
    end else begin
      if (!cmd.idx[0]) begin
        exp_t = aes_pkg::sub_word({prev1[23:0], prev1[31:24]}) ^ {rcon, 24'h0};
      end else begin
        exp_t = aes_pkg::sub_word(prev1[31:0]);
      end
      exp_row[127:96] = prev2[127:96] ^ exp_t;
      exp_row[95:64]  = prev2[95:64] ^ exp_row[127:96];
      exp_row[63:32]  = prev2[63:32] ^ exp_row[95:64];
      exp_row[31:0]   = prev2[31:0] ^ exp_row[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      round_key[cmd.idx[aes_pkg::IDX_W-1:0]] <= exp_row;
      prev2 <= prev1;
      prev1 <= exp_row;
      if (cmd.idx == '0) begin
        rcon <= aes_pkg::RCON_FIRST;
      end else if (cmd.idx != aes_pkg::IDX_W'(1) && !cmd.idx[0]) begin
        rcon <= aes_pkg::xtime(rcon);
      end
    end
  end

  // round datapath
  assign key_idx = decrypt ? aes_pkg::IDX_W'(aes_pkg::ROUNDS - int'(cmd.idx)) : cmd.idx;
  assign rk_sel  = round_key[cmd.load ? (decrypt ? aes_pkg::IDX_W'(aes_pkg::ROUNDS) : '0)
                                      : key_idx];
  assign last    = (cmd.idx == aes_pkg::IDX_W'(aes_pkg::ROUNDS));

  assign chain_use = start_of_message ? iv : chain;

  always_comb begin
    enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(state, 1'b0), 1'b0);
    if (!last) begin
      enc_t = aes_pkg::mix_columns(enc_t, 1'b0);
    end
    enc_t = enc_t ^ rk_sel;
    dec_t = aes_pkg::sub_bytes(aes_pkg::shift_rows(state, 1'b1), 1'b1) ^ rk_sel;
    if (!last) begin
      dec_t = aes_pkg::mix_columns(dec_t, 1'b1);
    end
    round_out = decrypt ? dec_t : enc_t;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      saved_in <= block_in;
      if (cbc && !decrypt) begin
        state <= block_in ^ chain_use ^ rk_sel;
      end else begin
        state <= block_in ^ rk_sel;
      end
    end else if (cmd.step) begin
      state <= round_out;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.load && start_of_message) begin
      chain <= iv;
    end else if (cmd.finish && cbc) begin
      chain <= decrypt ? saved_in : state;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cbc && decrypt) begin
        {result_high, result_low} <= state ^ chain;
      end else begin
        {result_high, result_low} <= state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== hdl/aes256_block_cipher_ecb_cbc.sv =====
// aes256_block_cipher_ecb_cbc: aes-256 cipher with ecb or cbc chaining, top level
// depends on aes_pkg, aes_ctrl, aes_dp
//
//  channel  signals                                         direction
//  cfg      cfg_valid cfg_ready cfg_index cfg_data          write registers
//  in       in_valid in_ready block_high block_low start_of_message  blocks in
//  out      out_valid out_ready result_high result_low      blocks out
//
// for one block, the input transaction does the first key add, the shared round
// unit then runs 14 rounds, one per cycle, and the done state loads the output
// register once it is free. a key register write starts an expansion of 15
// schedule rows, one per cycle, during which no transaction is taken.
// reset clears control, configuration and the chaining value; the round key
// store holds nothing until a key register is written.
// a result waiting on out_ready does not block the next input transaction.
`timescale 1ns / 1ps

module aes256_block_cipher_ecb_cbc (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  // input blocks
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    block_high,
  input  logic [63:0]                    block_low,
  input  logic                           start_of_message,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    result_high,
  output logic [63:0]                    result_low
);

  // configuration registers
  logic [63:0] key_word_3, key_word_2, key_word_1, key_word_0;
  logic [63:0] iv_high, iv_low;
  logic        chain_mode, direction;
  logic        cfg_fire;

  aes_pkg::dp_cmd_t    cmd;
  aes_pkg::dp_status_t status;

  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_3 <= '0;
      key_word_2 <= '0;
      key_word_1 <= '0;
      key_word_0 <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
      chain_mode <= 1'b0;
      direction  <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        aes_pkg::REG_KEY_WORD_3: key_word_3 <= cfg_data;
        aes_pkg::REG_KEY_WORD_2: key_word_2 <= cfg_data;
        aes_pkg::REG_KEY_WORD_1: key_word_1 <= cfg_data;
        aes_pkg::REG_KEY_WORD_0: key_word_0 <= cfg_data;
        aes_pkg::REG_IV_HIGH:    iv_high    <= cfg_data;
        aes_pkg::REG_IV_LOW:     iv_low     <= cfg_data;
        aes_pkg::REG_CHAIN_MODE: chain_mode <= cfg_data[0];
        aes_pkg::REG_DIRECTION:  direction  <= cfg_data[0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // sequencer: picks expansion or block processing, counts rows and rounds
  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: key schedule, round unit, chaining, output register
  aes_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .key              ({key_word_3, key_word_2, key_word_1, key_word_0}),
    .iv               ({iv_high, iv_low}),
    .cbc              (chain_mode),
    .decrypt          (direction),
    .block_in         ({block_high, block_low}),
    .start_of_message (start_of_message),
    .result_high      (result_high),
    .result_low       (result_low),
    .out_valid        (out_valid),
    .out_ready        (out_ready)
  );

endmodule
